// ===== hw/rtl/vtm_pkg.sv =====
// ----------------------------------------------------------------------------
// vtm_pkg: shared types and constants of the virtual timer multiplexer
//
// Slot entry layout, item codes and field widths used by the top level and
// the slot memory.
// ----------------------------------------------------------------------------
package vtm_pkg;

  // table geometry
  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned PRIO_W    = 3;

  // input item opcodes (carried on tuser)
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_STOP   = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // result item kinds (carried on tuser)
  typedef enum logic [2:0] {
    KIND_STARTED = 3'd0,
    KIND_STOPPED = 3'd1,
    KIND_FIRED   = 3'd2,
    KIND_HW_UPD  = 3'd3,
    KIND_FULL    = 3'd4
  } kind_e;

  // hardware countdown action
  typedef enum logic [1:0] {
    HW_LEAVE = 2'd0,
    HW_START = 2'd1,
    HW_STOP  = 2'd2
  } hw_e;

  // one slot of the timer table; the running flag lives in flip-flops
  typedef struct packed {
    logic              periodic;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] remaining;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } slot_entry_t;

endpackage

// ===== hw/rtl/vtm_slot_mem.sv =====
// ----------------------------------------------------------------------------
// vtm_slot_mem: timer slot table
//
// One write port and one read port, read data registered.
// Contents need no reset: an entry is only read while its running flag is set,
// and a start always writes the whole entry first.
// ----------------------------------------------------------------------------
module vtm_slot_mem (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [vtm_pkg::SLOT_W-1:0]  wr_addr_i,
  input  vtm_pkg::slot_entry_t        wr_data_i,
  input  logic                        rd_en_i,
  input  logic [vtm_pkg::SLOT_W-1:0]  rd_addr_i,
  output vtm_pkg::slot_entry_t        rd_data_o
);
  import vtm_pkg::*;

  slot_entry_t mem_q [NUM_SLOTS];
  slot_entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/virtual_timer_multiplexer.sv =====
// ----------------------------------------------------------------------------
// virtual_timer_multiplexer: sixteen software timers on one hardware countdown
//
// Start, stop and expire items in; started/stopped/fired/update results out.
// ----------------------------------------------------------------------------
// One item is handled at a time. A start, stop or unused opcode passes a
// capture and an execute step, plus any wait for the output register to drain.
// An expire walks the slot table through the single read port of the slot
// memory: after capture and setup, a stopped slot is skipped and a running
// slot is read, then updated and written back; the end of the walk and a
// final update follow, and a stall on the result side lengthens it. Each
// expire returns one fired item per slot that reached zero and a final
// hardware update item marked by tlast.
// The next input item is taken once the previous one has issued its last
// result into the output register, even if that result is still waiting.
// ----------------------------------------------------------------------------
module virtual_timer_multiplexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] timer_type, [32:1] ticks, [48:33] task_tag, [51:49] priority_req,
  // [55:52] slot
  input  logic [55:0] s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser_i,
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] slot_id, [19:4] fired_tag, [22:20] fired_priority, [24:23] hw_action,
  // [56:25] hw_timeout, [63:57] zero
  output logic [63:0] m_axis_tdata_o,
  // [2:0] kind
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import vtm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_FINAL = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // captured input item
  op_e               in_op_q;
  logic              in_type_q;
  logic [TICK_W-1:0] in_ticks_q;
  logic [TAG_W-1:0]  in_tag_q;
  logic [PRIO_W-1:0] in_prio_q;
  logic [SLOT_W-1:0] in_slot_q;

  // control state
  logic [NUM_SLOTS-1:0] running_q, running_d;
  logic                 hw_running_q, hw_running_d;
  logic [TICK_W-1:0]    cur_tmo_q, cur_tmo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 found_q, found_d;
  logic [TICK_W-1:0]    best_q, best_d;

  // output register
  logic              out_valid_q;
  kind_e             out_kind_q, out_kind_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [TAG_W-1:0]  out_tag_q, out_tag_d;
  logic [PRIO_W-1:0] out_prio_q, out_prio_d;
  hw_e               out_act_q, out_act_d;
  logic [TICK_W-1:0] out_tmo_q, out_tmo_d;
  logic              out_last_q, out_last_d;
  logic              out_push;
  logic              out_free;

  // slot memory ports
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_entry_t       mem_wdata;
  logic              mem_re;
  slot_entry_t       mem_rdata;

  // scan datapath
  logic [SLOT_W-1:0] scan_idx;
  logic [TICK_W-1:0] dec_rem;
  logic              fire;
  logic              keep;
  logic [TICK_W-1:0] next_rem;

  // first stopped slot
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  logic in_accept;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign scan_idx        = cnt_q[SLOT_W-1:0];

  vtm_slot_mem u_slot_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (scan_idx),
    .rd_data_o (mem_rdata)
  );

  // lowest stopped slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!running_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // saturating decrement of the slot just read
  always_comb begin
    dec_rem  = (mem_rdata.remaining > cur_tmo_q) ? (mem_rdata.remaining - cur_tmo_q) : '0;
    fire     = (dec_rem == '0);
    keep     = !fire || mem_rdata.periodic;
    next_rem = fire ? mem_rdata.period : dec_rem;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    hw_running_d = hw_running_q;
    cur_tmo_d    = cur_tmo_q;
    cnt_d        = cnt_q;
    found_d      = found_q;
    best_d       = best_q;
    out_push     = 1'b0;
    out_kind_d   = KIND_STARTED;
    out_slot_d   = '0;
    out_tag_d    = '0;
    out_prio_d   = '0;
    out_act_d    = HW_LEAVE;
    out_tmo_d    = '0;
    out_last_d   = 1'b1;
    mem_we       = 1'b0;
    mem_waddr    = free_idx;
    mem_wdata    = '{periodic: in_type_q, period: in_ticks_q, remaining: in_ticks_q,
                     tag: in_tag_q, prio: in_prio_q};
    mem_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (in_op_q)
          OP_NONE: begin
            state_d = ST_IDLE;
          end
          OP_EXPIRE: begin
            cnt_d   = '0;
            found_d = 1'b0;
            best_d  = '0;
            state_d = ST_SCAN;
          end
          OP_STOP: begin
            if (out_free) begin
              out_push             = 1'b1;
              out_kind_d           = KIND_STOPPED;
              out_slot_d           = in_slot_q;
              running_d[in_slot_q] = 1'b0;
              state_d              = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              out_push = 1'b1;
              state_d  = ST_IDLE;
              if (!free_found) begin
                out_kind_d = KIND_FULL;
              end else begin
                mem_we              = 1'b1;
                running_d[free_idx] = 1'b1;
                out_kind_d          = KIND_STARTED;
                out_slot_d          = free_idx;
                if (!hw_running_q || (in_ticks_q < cur_tmo_q)) begin
                  cur_tmo_d    = in_ticks_q;
                  hw_running_d = 1'b1;
                  out_act_d    = HW_START;
                  out_tmo_d    = in_ticks_q;
                end
              end
            end
          end
        endcase
      end

      // step to the next running slot and issue its read
      ST_SCAN: begin
        if (cnt_q == CNT_W'(NUM_SLOTS)) begin
          state_d = ST_FINAL;
        end else if (running_q[scan_idx]) begin
          mem_re  = 1'b1;
          state_d = ST_EVAL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // update the slot, write it back, report a firing
      ST_EVAL: begin
        if (!fire || out_free) begin
          mem_we          = 1'b1;
          mem_waddr       = scan_idx;
          mem_wdata       = mem_rdata;
          mem_wdata.remaining = next_rem;
          if (!keep) begin
            running_d[scan_idx] = 1'b0;
          end else if (!found_q || (next_rem < best_q)) begin
            found_d = 1'b1;
            best_d  = next_rem;
          end
          if (fire) begin
            out_push   = 1'b1;
            out_kind_d = KIND_FIRED;
            out_slot_d = scan_idx;
            out_tag_d  = mem_rdata.tag;
            out_prio_d = mem_rdata.prio;
            out_last_d = 1'b0;
          end
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_SCAN;
        end
      end

      // reload or stop the hardware countdown
      ST_FINAL: begin
        if (out_free) begin
          out_push   = 1'b1;
          out_kind_d = KIND_HW_UPD;
          state_d    = ST_IDLE;
          if (found_q) begin
            cur_tmo_d    = best_q;
            hw_running_d = 1'b1;
            out_act_d    = HW_START;
            out_tmo_d    = best_q;
          end else begin
            hw_running_d = 1'b0;
            out_act_d    = HW_STOP;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      running_q    <= '0;
      hw_running_q <= 1'b0;
      cur_tmo_q    <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      best_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      hw_running_q <= hw_running_d;
      cur_tmo_q    <= cur_tmo_d;
      cnt_q        <= cnt_d;
      found_q      <= found_d;
      best_q       <= best_d;
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q    <= op_e'(s_axis_tuser_i);
      in_type_q  <= s_axis_tdata_i[0];
      in_ticks_q <= s_axis_tdata_i[32:1];
      in_tag_q   <= s_axis_tdata_i[48:33];
      in_prio_q  <= s_axis_tdata_i[51:49];
      in_slot_q  <= s_axis_tdata_i[55:52];
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_kind_q <= out_kind_d;
      out_slot_q <= out_slot_d;
      out_tag_q  <= out_tag_d;
      out_prio_q <= out_prio_d;
      out_act_q  <= out_act_d;
      out_tmo_q  <= out_tmo_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {7'b0, out_tmo_q, out_act_q, out_prio_q, out_tag_q, out_slot_q};

  // scan counter never runs past the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_SLOTS))
    else $error("scan counter beyond table");

  // only running slots are read and updated
  a_eval_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> running_q[scan_idx])
    else $error("evaluating a stopped slot");

  // a successful final step with a running slot leaves the countdown on
  a_final_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL && out_free && found_q) |=> (hw_running_q && cur_tmo_q == out_tmo_q))
    else $error("hardware countdown not reloaded");

  // a result is never overwritten while it waits
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !out_push)
    else $error("output register overrun");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of the virtual timer multiplexer
//
// A short table of directed items (timer start/stop/expire corner cases,
// a full table, an unused opcode) is followed by random items. Each accepted
// item runs through a behavioral timer-table model. The model's results are
// queued and matched field by field against every result item the block
// emits. Both stream sides idle in random bursts. The result side also holds
// off once for a long stretch, and the sender pauses once until the block
// has drained.
// ----------------------------------------------------------------------------
module testbench;
  import vtm_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 290;
  localparam int unsigned CALM_TAIL     = 40;
  localparam int unsigned HOLD_AT_ITEM  = 100;
  localparam int unsigned PAUSE_AT_ITEM = 200;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam longint     TIME_LIMIT_NS = 64'd8_000_000;

  // one result item as seen on the master side
  typedef struct {
    kind_e              kind;
    logic [SLOT_W-1:0]  slot_id;
    logic [TAG_W-1:0]   tag;
    logic [PRIO_W-1:0]  prio;
    hw_e                act;
    logic [TICK_W-1:0]  timeout;
    logic               last;
  } timer_result_t;

  // one input item, with an optional hand-written expected result
  typedef struct {
    op_e                op;
    logic               periodic;
    logic [TICK_W-1:0]  ticks;
    logic [TAG_W-1:0]   tag;
    logic [PRIO_W-1:0]  prio;
    logic [SLOT_W-1:0]  slot;
    logic               typed;
    timer_result_t      want;
  } timer_cmd_t;

  // DUT connections
  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // timer table model state
  logic              tbl_run    [NUM_SLOTS];
  logic              tbl_per    [NUM_SLOTS];
  logic [TICK_W-1:0] tbl_period [NUM_SLOTS];
  logic [TICK_W-1:0] tbl_left   [NUM_SLOTS];
  logic [TAG_W-1:0]  tbl_tag    [NUM_SLOTS];
  logic [PRIO_W-1:0] tbl_prio   [NUM_SLOTS];
  logic              hw_on;
  logic [TICK_W-1:0] hw_timeout;

  timer_result_t step_results[$];
  timer_result_t expected_results[$];
  timer_cmd_t    directed[$];

  int unsigned mismatches = 0;
  int unsigned n_start = 0, n_stop = 0, n_expire = 0, n_ignored = 0;
  int unsigned n_fired = 0, n_full = 0, n_results = 0;
  int unsigned real_items = 0;
  logic        calm_tail  = 1'b0;
  logic        hold_req   = 1'b0;
  logic        rx_holding = 1'b0;

  virtual_timer_multiplexer i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #6 clk = ~clk;

  function automatic timer_result_t mk_result(kind_e k, logic [SLOT_W-1:0] sid,
                                              logic [TAG_W-1:0] tag,
                                              logic [PRIO_W-1:0] prio, hw_e a,
                                              logic [TICK_W-1:0] tmo, logic last);
    timer_result_t r;
    r.kind    = k;
    r.slot_id = sid;
    r.tag     = tag;
    r.prio    = prio;
    r.act     = a;
    r.timeout = tmo;
    r.last    = last;
    return r;
  endfunction

  function automatic timer_cmd_t cmd(op_e op, logic periodic, logic [TICK_W-1:0] ticks,
                                     logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                                     logic [SLOT_W-1:0] slot);
    timer_cmd_t c;
    c.op       = op;
    c.periodic = periodic;
    c.ticks    = ticks;
    c.tag      = tag;
    c.prio     = prio;
    c.slot     = slot;
    c.typed    = 1'b0;
    c.want     = mk_result(KIND_STARTED, '0, '0, '0, HW_LEAVE, '0, 1'b1);
    return c;
  endfunction

  // attach a single, hand-derived result to a directed row
  function automatic timer_cmd_t expecting(timer_cmd_t c, kind_e k,
                                           logic [SLOT_W-1:0] sid, hw_e a,
                                           logic [TICK_W-1:0] tmo);
    c.typed = 1'b1;
    c.want  = mk_result(k, sid, '0, '0, a, tmo, 1'b1);
    return c;
  endfunction

  // random item: mostly short delays so that expiries actually fire
  function automatic timer_cmd_t random_cmd();
    int unsigned  pick;
    op_e          op;
    logic [31:0]  ticks;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_START;
    else if (pick < 60) op = OP_STOP;
    else if (pick < 95) op = OP_EXPIRE;
    else                op = OP_NONE;
    case ($urandom_range(0, 9))
      0:       ticks = '0;
      1:       ticks = '1;
      2:       ticks = $urandom();
      default: ticks = $urandom_range(1, 400);
    endcase
    return cmd(op, 1'($urandom()), ticks, 16'($urandom()), 3'($urandom()),
               4'($urandom()));
  endfunction

  task automatic clear_slot_entry(input int unsigned idx);
    tbl_run[idx]    = 1'b0;
    tbl_per[idx]    = 1'b0;
    tbl_period[idx] = '0;
    tbl_left[idx]   = '0;
    tbl_tag[idx]    = '0;
    tbl_prio[idx]   = '0;
  endtask

  // advance the timer table by one item; results land in step_results
  task automatic advance_timer_table(input timer_cmd_t c);
    int unsigned       idx;
    logic              found;
    logic [TICK_W-1:0] best;
    step_results.delete();
    found = 1'b0;
    best  = '0;
    case (c.op)
      OP_START: begin
        n_start++;
        idx = 0;
        while (idx < NUM_SLOTS && tbl_run[idx]) idx++;
        if (idx >= NUM_SLOTS) begin
          n_full++;
          step_results.push_back(mk_result(KIND_FULL, '0, '0, '0, HW_LEAVE, '0, 1'b1));
        end else begin
          tbl_run[idx]    = 1'b1;
          tbl_per[idx]    = c.periodic;
          tbl_period[idx] = c.ticks;
          tbl_left[idx]   = c.ticks;
          tbl_tag[idx]    = c.tag;
          tbl_prio[idx]   = c.prio;
          // preemption does not credit elapsed time to other slots
          if (!hw_on || c.ticks < hw_timeout) begin
            hw_timeout = c.ticks;
            hw_on      = 1'b1;
            step_results.push_back(mk_result(KIND_STARTED, idx[SLOT_W-1:0], '0, '0,
                                             HW_START, c.ticks, 1'b1));
          end else begin
            step_results.push_back(mk_result(KIND_STARTED, idx[SLOT_W-1:0], '0, '0,
                                             HW_LEAVE, '0, 1'b1));
          end
        end
      end
      OP_STOP: begin
        n_stop++;
        clear_slot_entry(c.slot);
        step_results.push_back(mk_result(KIND_STOPPED, c.slot, '0, '0, HW_LEAVE, '0, 1'b1));
      end
      OP_EXPIRE: begin
        n_expire++;
        // charge the elapsed timeout, saturating at zero
        for (idx = 0; idx < NUM_SLOTS; idx++) begin
          if (tbl_run[idx]) begin
            if (tbl_left[idx] > hw_timeout) tbl_left[idx] = tbl_left[idx] - hw_timeout;
            else                            tbl_left[idx] = '0;
            if (tbl_left[idx] == '0) begin
              n_fired++;
              step_results.push_back(mk_result(KIND_FIRED, idx[SLOT_W-1:0], tbl_tag[idx],
                                               tbl_prio[idx], HW_LEAVE, '0, 1'b0));
              if (tbl_per[idx]) tbl_left[idx] = tbl_period[idx];
              else              clear_slot_entry(idx);
            end
          end
        end
        // next hardware load is the smallest remaining count
        for (idx = 0; idx < NUM_SLOTS; idx++) begin
          if (tbl_run[idx] && (!found || tbl_left[idx] < best)) begin
            best  = tbl_left[idx];
            found = 1'b1;
          end
        end
        if (found) begin
          hw_timeout = best;
          hw_on      = 1'b1;
          step_results.push_back(mk_result(KIND_HW_UPD, '0, '0, '0, HW_START, best, 1'b1));
        end else begin
          hw_on = 1'b0;
          step_results.push_back(mk_result(KIND_HW_UPD, '0, '0, '0, HW_STOP, '0, 1'b1));
        end
      end
      default: n_ignored++;
    endcase
  endtask

  // present one item and hold it until the block takes it
  task automatic offer_item(input timer_cmd_t c);
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {c.slot, c.prio, c.tag, c.ticks, c.periodic};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_timer_table(c);
    if (c.typed) expected_results.push_back(c.want);
    else foreach (step_results[k]) expected_results.push_back(step_results[k]);
  endtask

  // random input gaps, with quiet stretches and none near the end
  task automatic pace_sender();
    int unsigned gap;
    gap = 0;
    if (!calm_tail && !rx_holding && ((real_items / 25) % 3 != 2) &&
        $urandom_range(0, 99) < 30)
      gap = $urandom_range(1, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] got);
    if (exp !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, got);
    end
  endfunction

  // result side: random back-pressure plus one long hold-off
  initial begin : result_sink
    int unsigned cyc;
    int unsigned pct;
    logic        hold_done;
    cyc       = 0;
    pct       = 10;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       pct = 0;
          1:       pct = 10;
          default: pct = 30;
        endcase
      end
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        rx_holding = 1'b1;
        m_tready  <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready  <= 1'b1;
        rx_holding = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual kind %0d data 0x%0h",
                   $time, m_tuser, m_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("kind",           64'(want.kind),    64'(m_tuser));
        check_field("slot_id",        64'(want.slot_id), 64'(m_tdata[3:0]));
        check_field("fired_tag",      64'(want.tag),     64'(m_tdata[19:4]));
        check_field("fired_priority", 64'(want.prio),    64'(m_tdata[22:20]));
        check_field("hw_action",      64'(want.act),     64'(m_tdata[24:23]));
        check_field("hw_timeout",     64'(want.timeout), 64'(m_tdata[56:25]));
        check_field("tdata padding",  64'(0),            64'(m_tdata[63:57]));
        check_field("tlast",          64'(want.last),    64'(m_tlast));
      end
    end
  end

  initial begin : watchdog
    #(TIME_LIMIT_NS);
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus: directed table, then random items
  initial begin : stimulus
    timer_cmd_t c;
    logic       paused;
    paused = 1'b0;
    for (int unsigned k = 0; k < NUM_SLOTS; k++) clear_slot_entry(k);
    hw_on      = 1'b0;
    hw_timeout = '0;

    // expire with the countdown off, stop of a stopped slot
    directed.push_back(expecting(cmd(OP_EXPIRE, 1'b0, '0, '0, '0, '0),
                                 KIND_HW_UPD, 4'd0, HW_STOP, '0));
    directed.push_back(expecting(cmd(OP_STOP, 1'b0, '0, '0, '0, 4'd15),
                                 KIND_STOPPED, 4'd15, HW_LEAVE, '0));
    // first start loads the countdown; longest start leaves it; zero reloads it
    directed.push_back(expecting(cmd(OP_START, 1'b0, 32'd100, 16'hFFFF, 3'd7, '0),
                                 KIND_STARTED, 4'd0, HW_START, 32'd100));
    directed.push_back(expecting(cmd(OP_START, 1'b1, 32'hFFFF_FFFF, '0, '0, '0),
                                 KIND_STARTED, 4'd1, HW_LEAVE, '0));
    directed.push_back(expecting(cmd(OP_START, 1'b1, '0, 16'h1234, 3'd3, 4'd9),
                                 KIND_STARTED, 4'd2, HW_START, '0));
    // zero-period slot fires on the next expire, then is stopped
    directed.push_back(cmd(OP_EXPIRE, 1'b0, '0, '0, '0, '0));
    directed.push_back(expecting(cmd(OP_STOP, 1'b1, 32'd5, 16'h00FF, 3'd1, 4'd2),
                                 KIND_STOPPED, 4'd2, HW_LEAVE, '0));
    directed.push_back(cmd(OP_EXPIRE, 1'b1, '1, '1, '1, '0));
    // one-shot fires, then the all-ones periodic slot fires and reloads
    directed.push_back(cmd(OP_EXPIRE, 1'b0, '0, '0, '0, '0));
    directed.push_back(cmd(OP_EXPIRE, 1'b0, '0, '0, '0, '0));
    // fill every free slot, then overflow the table
    for (int k = 0; k < 15; k++)
      directed.push_back(cmd(OP_START, k[0], 32'(50 + 13 * k), 16'(16'h8000 >> k),
                             k[2:0], k[3:0]));
    directed.push_back(expecting(cmd(OP_START, 1'b1, 32'd7, 16'hABCD, 3'd5, '0),
                                 KIND_FULL, 4'd0, HW_LEAVE, '0));
    // unused opcode gives nothing
    directed.push_back(cmd(OP_NONE, 1'b1, '1, '1, '1, '1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      pace_sender();
      offer_item(directed[k]);
    end

    while (real_items < RANDOM_ITEMS) begin
      c = random_cmd();
      if (real_items >= RANDOM_ITEMS - CALM_TAIL) calm_tail = 1'b1;
      if (real_items == HOLD_AT_ITEM) hold_req = 1'b1;
      // let the block run dry once before continuing
      if (real_items == PAUSE_AT_ITEM && !paused) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end
      pace_sender();
      offer_item(c);
      if (c.op != OP_NONE) real_items++;
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d starts, %0d stops, %0d expiries, %0d unused opcodes;",
             n_start, n_stop, n_expire, n_ignored);
    $display("checked %0d results with %0d timer firings and %0d table-full errors.",
             n_results, n_fired, n_full);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
